FILE: rtl/tlca_pkg.sv
package tlca_pkg;

  // Field widths of the channels
  localparam int FIELD_W = 10;
  localparam int OP_W    = 2;
  localparam int DIST_W  = 11;

  // Default sizes handed to the top level
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  typedef logic [FIELD_W-1:0] node_t;
  typedef logic [DIST_W-1:0]  dist_t;

  localparam dist_t DIST_MAX = 11'h7FF;

  // Item opcodes; the spare code is dropped
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Result kinds
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_QD1,
    S_QD2,
    S_L1A,
    S_L1D,
    S_CMP,
    S_L2A,
    S_L2B,
    S_FU,
    S_FV,
    S_BX,
    S_BY,
    S_OUT
  } state_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic  valid;
    logic  kind;
    node_t lca;
    dist_t path_len;
  } res_t;

endpackage

FILE: rtl/tlca_in_if.sv
interface tlca_in_if import tlca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  node_t               node;
  node_t               parent_node;
  node_t               depth_in;
  node_t               other_node;

  modport source(output valid, output op, output node, output parent_node,
                 output depth_in, output other_node, input ready);
  modport sink(input valid, input op, input node, input parent_node,
               input depth_in, input other_node, output ready);
endinterface

FILE: rtl/tlca_out_if.sv
interface tlca_out_if import tlca_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  result_kind;
  node_t common_ancestor;
  dist_t distance;

  modport source(output valid, output result_kind, output common_ancestor,
                 output distance, input ready);
  modport sink(input valid, input result_kind, input common_ancestor,
               input distance, output ready);
endinterface

FILE: rtl/tree_lca_distance.sv
// Lowest common ancestor and path length on a rooted tree.
// in_ch takes three kinds of item: load (one node's parent and depth),
// build (fill the ancestor levels) and query (two nodes). out_ch gives one
// result per build or query: a done marker, or the common ancestor and the
// number of edges between the two nodes. Loads give no result.
// A load leaves the sequencer idle; the next item can follow at once.
// A query reads both depths, raises the deeper node level by level,
// compares the two, lifts both level by level while their ancestors
// differ and closes by reading both parents before handing over; its
// steps are paced by the single ancestor read port. The next item is
// taken once the result has been handed to the output register.
// A build walks (NODES-1)*(LEVELS-1) entries, one ancestor memory read
// per cycle.
// Results leave through an output register, so a finished result waits
// there while the next item is taken; while it is still held and another
// result is ready, the sequencer waits and in_ch.ready stays low.
// Reset clears the control state only; both memories keep their contents,
// and entries never loaded read as undefined.
module tree_lca_distance import tlca_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlca_in_if.sink    in_ch,
  tlca_out_if.source out_ch
);

  res_t  res;
  logic  res_ready;
  logic  out_valid_r;
  logic  out_kind_r;
  node_t out_lca_r;
  dist_t out_dist_r;

  tlca_seq #(.NODES(NODES), .LEVELS(LEVELS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res       (res),
    .res_ready (res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_kind_r <= res.kind;
      out_lca_r  <= res.lca;
      out_dist_r <= res.path_len;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_kind_r;
  assign out_ch.common_ancestor = out_lca_r;
  assign out_ch.distance        = out_dist_r;

  // No item is taken while the sequencer holds a result
  a_no_take_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");

  // A build or query occupies the sequencer for at least the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready
     && (in_ch.op == OP_BUILD || in_ch.op == OP_QUERY)) |=> !in_ch.ready)
    else $error("sequencer idle right after a build or query");

  // A blocked result holds until the output register frees
  a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_ready) |=> (res.valid && $stable(res)))
    else $error("pending result changed while blocked");

  // A build result carries zero fields
  a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_BUILD)
      |-> (out_lca_r == '0 && out_dist_r == '0))
    else $error("build result with nonzero fields");

endmodule

FILE: rtl/tlca_ram.sv
module tlca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with the same-cycle write passed through
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tlca_seq.sv
module tlca_seq import tlca_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tlca_in_if.sink   in_ch,
  output res_t      res,
  input  logic      res_ready
);

  localparam int IW     = $clog2(NODES);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NW     = (IW > FIELD_W) ? IW : FIELD_W;
  localparam int ADEPTH = LEVELS << IW;
  localparam int AAW    = $clog2(ADEPTH);
  localparam int DW     = LEVELS + 2;

  state_t          state_r, state_nxt;
  node_t           u_r, u_nxt, v_r, v_nxt;
  node_t           du_r, du_nxt, dv_r, dv_nxt;
  node_t           a_r, a_nxt;
  node_t           lca_r, lca_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [LW-1:0]   j_r, j_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic            kind_r, kind_nxt;
  logic            anc_zero_r;

  // Memory ports
  logic            dep_we;
  logic [IW-1:0]   dep_waddr;
  node_t           dep_wdata;
  node_t           dep_rnode;
  node_t           dep_rdata;
  logic            anc_we;
  logic [IW-1:0]   anc_wnode;
  logic [LW-1:0]   anc_wlvl;
  node_t           anc_wdata;
  logic [NW-1:0]   anc_rnode;
  logic [LW-1:0]   anc_rlvl;
  node_t           anc_rdata;
  node_t           anc_q;

  logic            in_take;
  logic            in_node_ok;
  logic            query_ok;
  logic            last_entry;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_node_ok  = (in_ch.node != '0) && (32'(in_ch.node) < NODES);
  assign query_ok    = in_node_ok && (in_ch.other_node != '0)
                       && (32'(in_ch.other_node) < NODES);
  assign last_entry  = (i_r == IW'(NODES - 1)) && (j_r == LW'(LEVELS - 1));

  // Ancestor of no node, or of a node out of range, is no node
  assign anc_q = anc_zero_r ? '0 : anc_rdata;

  tlca_ram #(.WIDTH(FIELD_W), .DEPTH(NODES)) u_depth_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (IW'(dep_rnode)),
    .rdata (dep_rdata)
  );

  tlca_ram #(.WIDTH(FIELD_W), .DEPTH(ADEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (AAW'({anc_wlvl, anc_wnode})),
    .wdata (anc_wdata),
    .raddr (AAW'({anc_rlvl, IW'(anc_rnode)})),
    .rdata (anc_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          case (in_ch.op)
            OP_BUILD: state_nxt = (LEVELS > 1) ? S_BX : S_OUT;
            OP_QUERY: state_nxt = query_ok ? S_QD1 : S_OUT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_QD1: state_nxt = S_QD2;
      S_QD2: state_nxt = S_L1A;
      S_L1A: begin
        if (anc_q != '0) begin
          state_nxt = S_L1D;
        end else if (j_r == '0) begin
          state_nxt = S_CMP;
        end
      end
      S_L1D: state_nxt = (j_r == '0) ? S_CMP : S_L1A;
      S_CMP: state_nxt = (u_r == v_r) ? S_OUT : S_L2A;
      S_L2A: state_nxt = S_L2B;
      S_L2B: state_nxt = (j_r == '0) ? S_FU : S_L2A;
      S_FU:  state_nxt = S_FV;
      S_FV:  state_nxt = S_OUT;
      S_BX: begin
        if (anc_q != '0) begin
          state_nxt = S_BY;
        end else if (last_entry) begin
          state_nxt = S_OUT;
        end
      end
      S_BY:  state_nxt = last_entry ? S_OUT : S_BX;
      S_OUT: state_nxt = res_ready ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    logic [NW-1:0] uu;
    logic [IW-1:0] i_adv;
    logic [LW-1:0] j_adv;

    uu        = '0;
    i_adv     = i_r;
    j_adv     = j_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    du_nxt    = du_r;
    dv_nxt    = dv_r;
    a_nxt     = a_r;
    lca_nxt   = lca_r;
    d_nxt     = d_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    kind_nxt  = kind_r;
    dep_we    = 1'b0;
    dep_waddr = IW'(in_ch.node);
    dep_wdata = in_ch.depth_in;
    dep_rnode = '0;
    anc_we    = 1'b0;
    anc_wnode = i_r;
    anc_wlvl  = j_r;
    anc_wdata = anc_q;
    anc_rnode = '0;
    anc_rlvl  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          case (in_ch.op)
            OP_LOAD: begin
              // Write level-0 parent and depth of a node in range
              if (in_node_ok) begin
                dep_we    = 1'b1;
                anc_we    = 1'b1;
                anc_wnode = IW'(in_ch.node);
                anc_wlvl  = '0;
                anc_wdata = (32'(in_ch.parent_node) < NODES) ? in_ch.parent_node : '0;
              end
            end
            OP_BUILD: begin
              kind_nxt  = KIND_BUILD;
              lca_nxt   = '0;
              d_nxt     = '0;
              i_nxt     = IW'(1);
              j_nxt     = LW'(1);
              anc_rnode = NW'(1);
              anc_rlvl  = '0;
            end
            OP_QUERY: begin
              kind_nxt  = KIND_QUERY;
              lca_nxt   = '0;
              d_nxt     = '0;
              u_nxt     = in_ch.node;
              v_nxt     = in_ch.other_node;
              dep_rnode = in_ch.node;
            end
            default: begin
              kind_nxt = kind_r;
            end
          endcase
        end
      end
      S_QD1: begin
        du_nxt    = dep_rdata;
        dep_rnode = v_r;
      end
      S_QD2: begin
        // Put the deeper node in u, keep the shallower depth as target
        uu = NW'(u_r);
        if (du_r < dep_rdata) begin
          u_nxt  = v_r;
          v_nxt  = u_r;
          dv_nxt = du_r;
          uu     = NW'(v_r);
        end else begin
          dv_nxt = dep_rdata;
        end
        j_nxt     = LW'(LEVELS - 1);
        anc_rnode = uu;
        anc_rlvl  = LW'(LEVELS - 1);
      end
      S_L1A: begin
        if (anc_q != '0) begin
          a_nxt     = anc_q;
          dep_rnode = anc_q;
        end else if (j_r != '0) begin
          j_nxt     = j_r - LW'(1);
          anc_rnode = NW'(u_r);
          anc_rlvl  = j_r - LW'(1);
        end
      end
      S_L1D: begin
        // Raise u when the ancestor is still at or below the target depth
        uu = NW'(u_r);
        if (dep_rdata >= dv_r) begin
          uu    = NW'(a_r);
          u_nxt = a_r;
          d_nxt = d_r + (DW'(1) << j_r);
        end
        if (j_r != '0) begin
          j_nxt     = j_r - LW'(1);
          anc_rnode = uu;
          anc_rlvl  = j_r - LW'(1);
        end
      end
      S_CMP: begin
        if (u_r == v_r) begin
          lca_nxt = u_r;
        end else begin
          j_nxt     = LW'(LEVELS - 1);
          anc_rnode = NW'(u_r);
          anc_rlvl  = LW'(LEVELS - 1);
        end
      end
      S_L2A: begin
        a_nxt     = anc_q;
        anc_rnode = NW'(v_r);
        anc_rlvl  = j_r;
      end
      S_L2B: begin
        // Lift both while their ancestors differ
        uu = NW'(u_r);
        if ((a_r != '0) && (a_r != anc_q)) begin
          uu    = NW'(a_r);
          u_nxt = a_r;
          v_nxt = anc_q;
          d_nxt = d_r + (DW'(2) << j_r);
        end
        anc_rnode = uu;
        if (j_r != '0) begin
          j_nxt    = j_r - LW'(1);
          anc_rlvl = j_r - LW'(1);
        end else begin
          anc_rlvl = '0;
        end
      end
      S_FU: begin
        a_nxt     = anc_q;
        anc_rnode = NW'(v_r);
        anc_rlvl  = '0;
      end
      S_FV: begin
        d_nxt   = d_r + DW'(a_r != '0) + DW'(anc_q != '0);
        lca_nxt = a_r;
      end
      S_BX, S_BY: begin
        if ((state_r == S_BX) && (anc_q != '0)) begin
          // Fetch the ancestor of the ancestor one level down
          anc_rnode = NW'(anc_q);
          anc_rlvl  = j_r - LW'(1);
        end else begin
          // Write the entry and advance to the next one
          anc_we    = 1'b1;
          anc_wnode = i_r;
          anc_wlvl  = j_r;
          anc_wdata = anc_q;
          if (!last_entry) begin
            if (i_r == IW'(NODES - 1)) begin
              i_adv = IW'(1);
              j_adv = j_r + LW'(1);
            end else begin
              i_adv = i_r + IW'(1);
            end
            i_nxt     = i_adv;
            j_nxt     = j_adv;
            anc_rnode = NW'(i_adv);
            anc_rlvl  = j_adv - LW'(1);
          end
        end
      end
      default: begin
        kind_nxt = kind_r;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    du_r       <= du_nxt;
    dv_r       <= dv_nxt;
    a_r        <= a_nxt;
    lca_r      <= lca_nxt;
    d_r        <= d_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    kind_r     <= kind_nxt;
    anc_zero_r <= (anc_rnode == '0) || (32'(anc_rnode) >= NODES);
  end

  // Present the finished result, distance saturated
  always_comb begin
    res.valid    = (state_r == S_OUT);
    res.kind     = kind_r;
    res.lca      = lca_r;
    res.path_len = (32'(d_r) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_r);
  end

endmodule
